>>> src/y420rgb_pkg.sv
// Shared types, constants and coefficient helper for the 4:2:0 block to RGB converter.
// No dependencies; used by y420rgb_lane and ycbcr420_block_to_rgb.
package y420rgb_pkg;

    localparam int FRACTION_BITS_DEF = 15;

    // Coefficients in thousandths, scaled to fixed point at elaboration
    localparam int COEF_Y_MILLI  = 1164;
    localparam int COEF_RV_MILLI = 1596;
    localparam int COEF_GU_MILLI = 391;
    localparam int COEF_GV_MILLI = 813;
    localparam int COEF_BU_MILLI = 2018;

    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_CENTRE = 128;

    typedef struct packed {
        logic [7:0] cb_sample;
        logic [7:0] cr_sample;
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
    } in_t;

    typedef struct packed {
        logic [23:0] pixel_top_left;
        logic [23:0] pixel_top_right;
        logic [23:0] pixel_bottom_left;
        logic [23:0] pixel_bottom_right;
    } out_t;

    // Load enables for the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // round(milli / 1000 * 2^fb), exact in integers
    function automatic longint coef_of(input longint milli, input int fb);
        longint scaled;
        scaled = milli * (longint'(1) << fb);
        return (scaled + 500) / 1000;
    endfunction

endpackage

>>> src/ycbcr420_block_to_rgb.sv
// Top level of the BT.601 limited-range 4:2:0 block to RGB converter.
// Depends on y420rgb_pkg and y420rgb_lane.

// Converts one 2x2 block (shared Cb/Cr, four luma samples) into four packed
// pixels, red in bits 0-7, green 8-15, blue 16-23. A block is accepted every
// cycle unless m_ready stalls the pipeline. Its result leaves on m_valid/m_data
// from the last of four register stages, which work as follows:
// stage 1 multiplies, stage 2 adds the luma bias and forms the chroma terms,
// stage 3 forms the channel sums, stage 4 clamps and holds the output. Each
// stage loads whenever it is empty or the stage after it moves. A stalled
// m_ready therefore fills the four stages before s_ready drops. No state
// survives between blocks.
module ycbcr420_block_to_rgb #(
    parameter int FRACTION_BITS = y420rgb_pkg::FRACTION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  y420rgb_pkg::in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output y420rgb_pkg::out_t m_data
);

    localparam int SUM_W = FRACTION_BITS + 12;

    localparam logic signed [SUM_W-1:0] COEF_RV =
        SUM_W'(y420rgb_pkg::coef_of(y420rgb_pkg::COEF_RV_MILLI, FRACTION_BITS));
    localparam logic signed [SUM_W-1:0] COEF_GU =
        SUM_W'(y420rgb_pkg::coef_of(y420rgb_pkg::COEF_GU_MILLI, FRACTION_BITS));
    localparam logic signed [SUM_W-1:0] COEF_GV =
        SUM_W'(y420rgb_pkg::coef_of(y420rgb_pkg::COEF_GV_MILLI, FRACTION_BITS));
    localparam logic signed [SUM_W-1:0] COEF_BU =
        SUM_W'(y420rgb_pkg::coef_of(y420rgb_pkg::COEF_BU_MILLI, FRACTION_BITS));
    localparam logic signed [8:0] C_CENTRE = 9'(y420rgb_pkg::CHROMA_CENTRE);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    rdy1, rdy2, rdy3, rdy4;
    y420rgb_pkg::stage_en_t  en;

    logic signed [8:0]       cb_diff, cr_diff;
    logic signed [SUM_W-1:0] rv_p_reg, gu_p_reg, gv_p_reg, bu_p_reg;
    logic signed [SUM_W-1:0] rc_reg, gc_reg, bc_reg;
    logic [7:0]              luma [4];
    logic [23:0]             pix  [4];

    // A stage may load when it is empty or its contents move on
    assign rdy4 = !v4_reg || m_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign cb_diff = $signed({1'b0, s_data.cb_sample}) - C_CENTRE;
    assign cr_diff = $signed({1'b0, s_data.cr_sample}) - C_CENTRE;

    // Shared chroma terms, one per block
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            rv_p_reg <= COEF_RV * SUM_W'(cr_diff);
            gu_p_reg <= COEF_GU * SUM_W'(cb_diff);
            gv_p_reg <= COEF_GV * SUM_W'(cr_diff);
            bu_p_reg <= COEF_BU * SUM_W'(cb_diff);
        end
        if (en.s2) begin
            rc_reg <= rv_p_reg;
            gc_reg <= SUM_W'(0) - gu_p_reg - gv_p_reg;
            bc_reg <= bu_p_reg;
        end
    end

    assign luma[0] = s_data.luma_top_left;
    assign luma[1] = s_data.luma_top_right;
    assign luma[2] = s_data.luma_bottom_left;
    assign luma[3] = s_data.luma_bottom_right;

    for (genvar k = 0; k < 4; k++) begin : g_lane
        y420rgb_lane #(
            .FRACTION_BITS (FRACTION_BITS),
            .SUM_W         (SUM_W)
        ) u_lane (
            .aclk  (aclk),
            .en    (en),
            .luma  (luma[k]),
            .rc    (rc_reg),
            .gc    (gc_reg),
            .bc    (bc_reg),
            .pixel (pix[k])
        );
    end

    assign m_data.pixel_top_left     = pix[0];
    assign m_data.pixel_top_right    = pix[1];
    assign m_data.pixel_bottom_left  = pix[2];
    assign m_data.pixel_bottom_right = pix[3];

    // An empty output stage never holds back the input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with output stage empty");

    // A result only appears from a block that was in stage 3
    a_out_from_stage3: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v3_reg))
        else $error("m_valid rose without a block in stage 3");

    // Full pipeline under stall takes no new transaction
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("transaction accepted into a full stalled pipeline");

endmodule

>>> src/y420rgb_lane.sv
// One pixel lane: luma multiply, bias, channel sums, clamp and pack.
// Depends on y420rgb_pkg; chroma terms come in from the top level at stage 2.
module y420rgb_lane #(
    parameter int FRACTION_BITS = y420rgb_pkg::FRACTION_BITS_DEF,
    parameter int SUM_W         = FRACTION_BITS + 12
) (
    input  logic                    aclk,
    input  y420rgb_pkg::stage_en_t  en,
    input  logic [7:0]              luma,
    input  logic signed [SUM_W-1:0] rc,
    input  logic signed [SUM_W-1:0] gc,
    input  logic signed [SUM_W-1:0] bc,
    output logic [23:0]             pixel
);

    localparam logic signed [SUM_W-1:0] COEF_Y =
        SUM_W'(y420rgb_pkg::coef_of(y420rgb_pkg::COEF_Y_MILLI, FRACTION_BITS));
    localparam logic signed [SUM_W-1:0] Y_BIAS = SUM_W'(FRACTION_BITS / 2);
    localparam logic signed [8:0] Y_OFS = 9'(y420rgb_pkg::LUMA_OFFSET);

    logic signed [8:0]       ydiff;
    logic signed [SUM_W-1:0] yprod_reg;
    logic signed [SUM_W-1:0] yt_reg;
    logic signed [SUM_W-1:0] r_sum_reg, g_sum_reg, b_sum_reg;
    logic [23:0]             pixel_reg;
    logic [23:0]             pixel_next;

    assign ydiff = $signed({1'b0, luma}) - Y_OFS;

    function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
        logic [7:0] v;
        if (s[SUM_W-1]) begin
            v = 8'd0;
        end else if (|s[SUM_W-2:FRACTION_BITS+8]) begin
            v = 8'hFF;
        end else begin
            v = s[FRACTION_BITS+7:FRACTION_BITS];
        end
        return v;
    endfunction

    assign pixel_next = {clamp8(b_sum_reg), clamp8(g_sum_reg), clamp8(r_sum_reg)};

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            yprod_reg <= COEF_Y * SUM_W'(ydiff);
        end
        if (en.s2) begin
            yt_reg <= yprod_reg + Y_BIAS;
        end
        if (en.s3) begin
            r_sum_reg <= yt_reg + rc;
            g_sum_reg <= yt_reg + gc;
            b_sum_reg <= yt_reg + bc;
        end
        if (en.s4) begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule
